>>> hdl/assert_macros.svh
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: label");

`endif

>>> hdl/bfvt_pkg.sv
// Package of types and constants for the box-against-frustum visibility test.
`default_nettype none

package bfvt_pkg;

    // Number of clip planes, one cell each.
    localparam int NUM_PLANES = 6;

    // Configuration port widths.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Pipeline stages in one cell and in the whole chain.
    localparam int CELL_STAGES = 2;
    localparam int CHAIN_DEPTH = NUM_PLANES * CELL_STAGES;

    // One plane as packed in its register: w in the top bits, x in the bottom.
    typedef struct packed {
        logic signed [27:0] w;
        logic signed [11:0] z;
        logic signed [11:0] y;
        logic signed [11:0] x;
    } t_plane;

    // One box word.
    typedef struct packed {
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
        logic        [14:0] half_x;
        logic        [14:0] half_y;
        logic        [14:0] half_z;
    } t_box;

    // What travels from cell to cell: the box and its verdict so far.
    typedef struct packed {
        logic vis;
        t_box box;
    } t_tok;

endpackage

`default_nettype wire

>>> hdl/bfvt_if.sv
// Stream interfaces for box words in and visibility words out.
`default_nettype none

interface bfvt_box_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] center_x;
    logic signed [15:0] center_y;
    logic signed [15:0] center_z;
    logic        [14:0] half_x;
    logic        [14:0] half_y;
    logic        [14:0] half_z;

    modport source (
        output valid, center_x, center_y, center_z, half_x, half_y, half_z,
        input  ready
    );
    modport sink (
        input  valid, center_x, center_y, center_z, half_x, half_y, half_z,
        output ready
    );
endinterface

interface bfvt_vis_if;
    logic valid;
    logic ready;
    logic visible;

    modport source (output valid, visible, input ready);
    modport sink (input valid, visible, output ready);
endinterface

`default_nettype wire

>>> hdl/bfvt_cell.sv
// One plane cell: holds a clip plane and tests each passing box against it.
`default_nettype none

module bfvt_cell (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_plane_we,
    input  logic [63:0]       i_plane_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  bfvt_pkg::t_tok    i_tok,
    output logic              o_valid,
    input  logic              i_ready,
    output bfvt_pkg::t_tok    o_tok
);

    bfvt_pkg::t_plane r_plane;

    logic               r_v1, r_v2;
    logic               ld1, ld2;
    bfvt_pkg::t_tok     r_tok1, r_tok2;
    logic signed [27:0] r_w;
    logic signed [29:0] r_prod_x, r_prod_y, r_prod_z;
    logic signed [17:0] sel_x, sel_y, sel_z;
    logic signed [29:0] n_prod_x, n_prod_y, n_prod_z;
    logic signed [31:0] margin;
    logic               pass;

    // Plane register, written from the configuration port.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plane <= '0;
        end else if (i_plane_we) begin
            r_plane <= bfvt_pkg::t_plane'(i_plane_data);
        end
    end

    // Each stage loads when it is empty or its word moves on.
    assign ld2     = !r_v2 || i_ready;
    assign ld1     = !r_v1 || ld2;
    assign o_ready = ld1;

    // Per axis, p*c + |p|*h equals p*(c+h) for p >= 0 and p*(c-h) for p < 0.
    always_comb begin
        sel_x = r_plane.x[11]
              ? 18'(i_tok.box.center_x) - 18'($signed({1'b0, i_tok.box.half_x}))
              : 18'(i_tok.box.center_x) + 18'($signed({1'b0, i_tok.box.half_x}));
        sel_y = r_plane.y[11]
              ? 18'(i_tok.box.center_y) - 18'($signed({1'b0, i_tok.box.half_y}))
              : 18'(i_tok.box.center_y) + 18'($signed({1'b0, i_tok.box.half_y}));
        sel_z = r_plane.z[11]
              ? 18'(i_tok.box.center_z) - 18'($signed({1'b0, i_tok.box.half_z}))
              : 18'(i_tok.box.center_z) + 18'($signed({1'b0, i_tok.box.half_z}));
        n_prod_x = r_plane.x * sel_x;
        n_prod_y = r_plane.y * sel_y;
        n_prod_z = r_plane.z * sel_z;
    end

    // First stage: the three products.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (ld1) begin
            r_v1 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld1 && i_valid) begin
            r_tok1   <= i_tok;
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
            r_w      <= r_plane.w;
        end
    end

    // Second stage: the box passes when d + r is above zero.
    assign margin = 32'(r_prod_x) + 32'(r_prod_y) + 32'(r_prod_z) + 32'(r_w);
    assign pass   = margin > 32'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (ld2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld2 && r_v1) begin
            r_tok2.box <= r_tok1.box;
            r_tok2.vis <= r_tok1.vis && pass;
        end
    end

    assign o_valid = r_v2;
    assign o_tok   = r_tok2;

endmodule

`default_nettype wire

>>> hdl/box_frustum_visibility_test_core.sv
// A box word taken at the input passes both stages of every cell, then leaves as a visibility word.
// Throughput: one box per cycle unless the output stalls; six cells of two stages, one multiplier per axis.
// Bubbles in the chain close up, so input is taken while an output word waits and a stage is empty.
// Reset clears all plane registers and valid flags; with zero planes every box is culled.
`default_nettype none

module box_frustum_visibility_test_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    bfvt_box_if.sink                             i_box,
    bfvt_vis_if.source                           o_vis,
    input  logic                                 i_cfg_we,
    input  logic [bfvt_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [bfvt_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    logic           valid [bfvt_pkg::NUM_PLANES+1];
    logic           ready [bfvt_pkg::NUM_PLANES+1];
    bfvt_pkg::t_tok tok   [bfvt_pkg::NUM_PLANES+1];

    // Chain entry: every box starts out visible.
    assign valid[0]           = i_box.valid;
    assign i_box.ready        = ready[0];
    assign tok[0].vis         = 1'b1;
    assign tok[0].box.center_x = i_box.center_x;
    assign tok[0].box.center_y = i_box.center_y;
    assign tok[0].box.center_z = i_box.center_z;
    assign tok[0].box.half_x   = i_box.half_x;
    assign tok[0].box.half_y   = i_box.half_y;
    assign tok[0].box.half_z   = i_box.half_z;

    // Row of plane cells; cell k holds register k.
    for (genvar k = 0; k < bfvt_pkg::NUM_PLANES; k++) begin : g_cell
        logic plane_we;
        assign plane_we = i_cfg_we && (i_cfg_idx == bfvt_pkg::CFG_IDX_W'(k));

        bfvt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_plane_we   (plane_we),
            .i_plane_data (i_cfg_data),
            .i_valid      (valid[k]),
            .o_ready      (ready[k]),
            .i_tok        (tok[k]),
            .o_valid      (valid[k+1]),
            .i_ready      (ready[k+1]),
            .o_tok        (tok[k+1])
        );
    end

    // Last cell's second stage is the output register.
    assign o_vis.valid                  = valid[bfvt_pkg::NUM_PLANES];
    assign o_vis.visible                = tok[bfvt_pkg::NUM_PLANES].vis;
    assign ready[bfvt_pkg::NUM_PLANES]  = o_vis.ready;

endmodule

`default_nettype wire

>>> hdl/bfvt_chk.sv
// Port-level checker for the visibility test core, with its bind.
`default_nettype none
`include "assert_macros.svh"

module bfvt_chk (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           i_in_valid,
    input logic                           i_in_ready,
    input logic                           i_out_valid,
    input logic                           i_out_ready,
    input logic                           i_out_visible,
    input logic                           i_cfg_we,
    input logic [bfvt_pkg::CFG_IDX_W-1:0] i_cfg_idx
);

    logic       in_acc, out_acc;
    logic [3:0] r_inflight;
    logic       r_cfg_seen;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // Words inside the chain.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + 4'(in_acc) - 4'(out_acc);
        end
    end

    // Set once any plane register has been written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_seen <= 1'b0;
        end else if (i_cfg_we && (i_cfg_idx < bfvt_pkg::CFG_IDX_W'(bfvt_pkg::NUM_PLANES))) begin
            r_cfg_seen <= 1'b1;
        end
    end

    // Every output word comes from an accepted box word.
    `ASSERT_IMPLIES(a_out_has_source, i_clk, i_rst_n, i_out_valid, r_inflight != 4'd0)

    // The chain never holds more words than it has stages.
    `ASSERT_IMPLIES(a_depth_bound, i_clk, i_rst_n, 1'b1, r_inflight <= 4'(bfvt_pkg::CHAIN_DEPTH))

    // With all planes still zero every box is culled.
    `ASSERT_IMPLIES(a_zero_planes_cull, i_clk, i_rst_n, i_out_valid && !r_cfg_seen, !i_out_visible)

    // A stalled output word keeps its verdict.
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_visible))

endmodule

bind box_frustum_visibility_test_core bfvt_chk u_bfvt_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_box.valid),
    .i_in_ready    (i_box.ready),
    .i_out_valid   (o_vis.valid),
    .i_out_ready   (o_vis.ready),
    .i_out_visible (o_vis.visible),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx)
);

`default_nettype wire

>>> test/box_frustum_visibility_test_core_tb.sv
// Self-checking testbench for the box-against-frustum visibility core.
`default_nettype none

module box_frustum_visibility_test_core_tb;

    // Register indexes of the configuration port; the last two select no plane.
    typedef enum logic [bfvt_pkg::CFG_IDX_W-1:0] {
        REG_RIGHT, REG_LEFT, REG_TOP, REG_BOTTOM, REG_FAR, REG_NEAR, REG_SPARE_A, REG_SPARE_B
    } t_reg_idx;

    localparam int RANDOM_PHASES = 8;
    localparam int BOXES_PER_PHASE = 240;
    localparam int IDLE_PERCENT = 6;
    localparam int MAX_REPORTS = 10;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [bfvt_pkg::CFG_IDX_W-1:0]  cfg_idx;
    logic [bfvt_pkg::CFG_DATA_W-1:0] cfg_data;
    bit                              calm;

    bfvt_box_if box_ch ();
    bfvt_vis_if vis_ch ();

    box_frustum_visibility_test_core i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_box      (box_ch),
        .o_vis      (vis_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // Testbench copy of the plane registers and the stores around the block.
    bfvt_pkg::t_plane plane_copy [bfvt_pkg::NUM_PLANES];
    bfvt_pkg::t_box   pending_boxes [$];
    logic             expected_vis [$];
    bfvt_pkg::t_box   drive_box;
    logic             want_vis;
    int               n_queued;
    int               n_taken;
    int               n_checked;
    int               n_visible;
    int               n_culled;
    int               n_errors;
    int               n_settings;

    // Free-running clock.
    always #5 clk = ~clk;

    // Absolute value of one plane coefficient.
    function automatic longint coeff_mag(logic signed [11:0] c);
        return (c < 0) ? -longint'(c) : longint'(c);
    endfunction

    // A box is culled as soon as one plane has it wholly on its back side.
    function automatic logic predict_visible(bfvt_pkg::t_box b);
        bfvt_pkg::t_plane p;
        longint plane_dist;
        longint reach;
        logic   vis;
        vis = 1'b1;
        for (int i = 0; i < bfvt_pkg::NUM_PLANES; i++) begin
            p = plane_copy[i];
            plane_dist = longint'(p.x) * longint'(b.center_x)
                       + longint'(p.y) * longint'(b.center_y)
                       + longint'(p.z) * longint'(b.center_z) + longint'(p.w);
            reach = longint'(b.half_x) * coeff_mag(p.x) + longint'(b.half_y) * coeff_mag(p.y)
                  + longint'(b.half_z) * coeff_mag(p.z);
            if (plane_dist <= -reach) begin
                vis = 1'b0;
            end
        end
        return vis;
    endfunction

    function automatic void log_failure(string msg);
        n_errors++;
        if (n_errors <= MAX_REPORTS) begin
            $display("ERROR: %s", msg);
        end
    endfunction

    function automatic bfvt_pkg::t_box mk_box(int cx, int cy, int cz, int hx, int hy, int hz);
        bfvt_pkg::t_box b;
        b.center_x = 16'(cx);
        b.center_y = 16'(cy);
        b.center_z = 16'(cz);
        b.half_x   = 15'(hx);
        b.half_y   = 15'(hy);
        b.half_z   = 15'(hz);
        return b;
    endfunction

    // Centers inside +-span (sometimes anywhere); extents mostly small, some full range.
    function automatic bfvt_pkg::t_box rand_box(int span);
        int c [3];
        int h [3];
        for (int a = 0; a < 3; a++) begin
            if (span >= 32767 || $urandom_range(7) == 0) begin
                c[a] = int'(16'($urandom));
            end else begin
                c[a] = int'($urandom_range(2 * span)) - span;
            end
            case ($urandom_range(3))
                0, 1: h[a] = $urandom_range(255);
                2: h[a] = $urandom_range(4095);
                default: h[a] = $urandom_range(32767);
            endcase
        end
        return mk_box(c[0], c[1], c[2], h[0], h[1], h[2]);
    endfunction

    function automatic void push_box(bfvt_pkg::t_box b);
        pending_boxes.push_back(b);
        n_queued++;
    endfunction

    // Waits until every box word has been taken and every result has come back.
    task automatic wait_idle();
        do begin
            @(posedge clk);
        end while (n_taken != n_queued || expected_vis.size() != 0);
    endtask

    task automatic write_plane(t_reg_idx idx, logic [bfvt_pkg::CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        if (idx < bfvt_pkg::NUM_PLANES) begin
            plane_copy[idx] = data;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_all_planes(bfvt_pkg::t_plane p);
        for (int i = 0; i < bfvt_pkg::NUM_PLANES; i++) begin
            write_plane(t_reg_idx'(i), p);
        end
        n_settings++;
    endtask

    // Six slabs bounding the cube |x|,|y|,|z| < bound, with small cross terms.
    task automatic load_frustum(int scale, int bound, int jitter);
        bfvt_pkg::t_plane p;
        for (int i = 0; i < bfvt_pkg::NUM_PLANES; i++) begin
            p.x = 12'(int'($urandom_range(2 * jitter)) - jitter);
            p.y = 12'(int'($urandom_range(2 * jitter)) - jitter);
            p.z = 12'(int'($urandom_range(2 * jitter)) - jitter);
            p.w = 28'(scale * bound);
            case (t_reg_idx'(i))
                REG_RIGHT:  p.x = 12'(-scale);
                REG_LEFT:   p.x = 12'(scale);
                REG_TOP:    p.y = 12'(-scale);
                REG_BOTTOM: p.y = 12'(scale);
                REG_FAR:    p.z = 12'(-scale);
                default:    p.z = 12'(scale);
            endcase
            write_plane(t_reg_idx'(i), p);
        end
        n_settings++;
    endtask

    task automatic load_random_planes();
        for (int i = 0; i < bfvt_pkg::NUM_PLANES; i++) begin
            write_plane(t_reg_idx'(i), {$urandom, $urandom});
        end
        write_plane($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, {$urandom, $urandom});
        n_settings++;
    endtask

    // Box word driver: holds a word until it is taken, then offers the next one.
    always @(posedge clk) begin
        if (!rst_n) begin
            box_ch.valid <= 1'b0;
        end else if (!box_ch.valid || box_ch.ready) begin
            if (pending_boxes.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
                drive_box = pending_boxes.pop_front();
                box_ch.valid    <= 1'b1;
                box_ch.center_x <= drive_box.center_x;
                box_ch.center_y <= drive_box.center_y;
                box_ch.center_z <= drive_box.center_z;
                box_ch.half_x   <= drive_box.half_x;
                box_ch.half_y   <= drive_box.half_y;
                box_ch.half_z   <= drive_box.half_z;
            end else begin
                box_ch.valid <= 1'b0;
            end
        end
    end

    // Each accepted box word yields one expected visibility word.
    always @(posedge clk) begin
        if (rst_n && box_ch.valid && box_ch.ready) begin
            expected_vis.push_back(predict_visible(mk_box(box_ch.center_x, box_ch.center_y,
                box_ch.center_z, box_ch.half_x, box_ch.half_y, box_ch.half_z)));
            n_taken++;
        end
    end

    // Visibility word monitor with random backpressure.
    always @(posedge clk) begin
        if (!rst_n) begin
            vis_ch.ready <= 1'b0;
        end else begin
            if (vis_ch.valid && vis_ch.ready) begin
                if (expected_vis.size() == 0) begin
                    log_failure($sformatf("visibility word %0b arrived with none expected",
                        vis_ch.visible));
                end else begin
                    want_vis = expected_vis.pop_front();
                    n_checked++;
                    if (want_vis) n_visible++;
                    else n_culled++;
                    if (vis_ch.visible !== want_vis) begin
                        log_failure($sformatf("word %0d: visible expected %0b, got %0b",
                            n_checked, want_vis, vis_ch.visible));
                    end
                end
            end
            vis_ch.ready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // Stimulus sequence.
    initial begin
        bfvt_pkg::t_plane p;
        int               bound;
        clk = 1'b0;
        rst_n = 1'b0;
        calm = 1'b0;
        cfg_we = 1'b0;
        cfg_idx = '0;
        cfg_data = '0;
        box_ch.valid = 1'b0;
        box_ch.center_x = '0;
        box_ch.center_y = '0;
        box_ch.center_z = '0;
        box_ch.half_x = '0;
        box_ch.half_y = '0;
        box_ch.half_z = '0;
        vis_ch.ready = 1'b0;
        for (int i = 0; i < bfvt_pkg::NUM_PLANES; i++) begin
            plane_copy[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // With all planes zero after reset, every box is culled.
        push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        push_box(mk_box(32767, 32767, 32767, 0, 0, 0));
        push_box(mk_box(0, 0, 0, 0, 0, 0));
        wait_idle();

        // Cube of half size 1000: boxes inside it and boxes touching or crossing its faces.
        load_frustum(16, 1000, 0);
        push_box(mk_box(0, 0, 0, 0, 0, 0));
        push_box(mk_box(1005, 0, 0, 5, 0, 0));
        push_box(mk_box(1004, 0, 0, 5, 0, 0));
        push_box(mk_box(-1005, 0, 0, 5, 0, 0));
        push_box(mk_box(0, 1005, 0, 0, 5, 0));
        push_box(mk_box(0, 0, -1005, 0, 0, 5));
        push_box(mk_box(0, 0, 1004, 0, 0, 5));
        push_box(mk_box(1000, 0, 0, 0, 0, 0));
        push_box(mk_box(999, 0, 0, 0, 0, 0));
        push_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767));
        push_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767));
        push_box(mk_box(-32768, 0, 0, 0, 0, 0));
        wait_idle();

        // Writes to indexes beyond the last plane must leave the planes alone.
        write_plane(REG_SPARE_A, '1);
        write_plane(REG_SPARE_B, '1);
        push_box(mk_box(0, 0, 0, 0, 0, 0));
        push_box(mk_box(1005, 0, 0, 5, 0, 0));
        wait_idle();

        // Extreme coefficients and offsets.
        p.x = 12'sh800;
        p.y = 12'sh800;
        p.z = 12'sh800;
        p.w = 28'sh7FFFFFF;
        set_all_planes(p);
        push_box(mk_box(32767, 32767, 32767, 0, 0, 0));
        push_box(mk_box(-32768, -32768, -32768, 0, 0, 0));
        wait_idle();
        p.x = 12'sh7FF;
        p.y = 12'sh7FF;
        p.z = 12'sh7FF;
        p.w = 28'sh8000000;
        set_all_planes(p);
        push_box(mk_box(0, 0, 0, 0, 0, 0));
        push_box(mk_box(0, 0, 0, 32767, 32767, 32767));
        wait_idle();
        set_all_planes('1);
        push_box(mk_box(0, 0, 0, 0, 0, 0));
        push_box(mk_box(0, 0, 0, 1, 0, 0));
        push_box(mk_box(0, 0, 0, 2, 0, 0));
        wait_idle();

        // Random phases, alternating bounded cubes and arbitrary planes.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            calm = (ph == 3);
            if (ph % 2 == 1) begin
                load_random_planes();
                for (int n = 0; n < BOXES_PER_PHASE; n++) begin
                    push_box(rand_box(32767));
                end
            end else begin
                bound = (ph == 0) ? 32767 : $urandom_range(64, 30000);
                load_frustum((ph == 0) ? 2047 : $urandom_range(1, 2047), bound,
                    $urandom_range(3));
                for (int n = 0; n < BOXES_PER_PHASE; n++) begin
                    push_box(rand_box((bound * 3 / 2 > 32767) ? 32767 : bound * 3 / 2));
                end
            end
            wait_idle();
        end
        calm = 1'b0;

        // Drain: any stray word during this time is caught by the monitor.
        repeat (2 * bfvt_pkg::CHAIN_DEPTH) @(posedge clk);
        if (expected_vis.size() != 0) begin
            log_failure($sformatf("%0d visibility words never arrived", expected_vis.size()));
        end
        $display("Checked %0d visibility words (%0d visible, %0d culled) over %0d plane sets.",
            n_checked, n_visible, n_culled, n_settings);
        $display("Mismatches and stray or missing words: %0d.", n_errors);
        if (n_errors == 0) begin
            $display("box_frustum_visibility_test_core_tb: PASS");
        end else begin
            $display("box_frustum_visibility_test_core_tb: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #2000000;
        $display("box_frustum_visibility_test_core_tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
